// ----- src/mbet_pkg.sv -----
// shared types, constants and register codes for the escape-time pixel block
package mbet_pkg;

    localparam int DEF_INDEX_BITS = 12;
    localparam int DEF_FRAC_BITS  = 28;

    localparam int ORIGIN_W    = 32;
    localparam int STEP_W      = 31;
    localparam int ITER_W      = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int DIV_STEP_W  = $clog2(ITER_W);

    localparam logic [CFG_INDEX_W-1:0] CFG_REAL_ORIGIN    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAG_ORIGIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REAL_STEP      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAG_STEP      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITERATIONS = 3'd4;

    localparam logic signed [ORIGIN_W-1:0] ORIGIN_RST = -32'sd536870912;
    localparam logic [STEP_W-1:0]          STEP_RST   = 31'd1073742;
    localparam logic [ITER_W-1:0]          ITER_RST   = 8'd40;
    localparam logic [ITER_W-1:0]          SHADE_SCALE = 8'd255;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_MUL,
        ST_C_INIT,
        ST_M_XY,
        ST_UPDATE,
        ST_M_XX,
        ST_M_YY,
        ST_TEST,
        ST_D_LOAD,
        ST_D_RUN,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MUL_XY,
        MUL_XX,
        MUL_YY
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     c_mul;
        logic     c_init;
        logic     mul_go;
        mul_sel_t mul_sel;
        logic     update;
        logic     test;
        logic     div_load;
        logic     div_go;
    } dp_cmd_t;

    typedef struct packed {
        logic bound_esc;
        logic sq_esc;
        logic at_limit;
        logic mul_last;
        logic div_last;
    } dp_status_t;

endpackage

// ----- src/mbet_dp.sv -----
// datapath: point forming, chunked complex multiply, escape tests and shade divider
module mbet_dp
    import mbet_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  dp_cmd_t                    cmd,
    input  logic [INDEX_BITS-1:0]      column,
    input  logic [INDEX_BITS-1:0]      row,
    input  logic signed [ORIGIN_W-1:0] real_origin,
    input  logic signed [ORIGIN_W-1:0] imag_origin,
    input  logic [STEP_W-1:0]          real_step,
    input  logic [STEP_W-1:0]          imag_step,
    input  logic [ITER_W-1:0]          limit,
    output dp_status_t                 status,
    output logic [ITER_W-1:0]          shade,
    output logic [ITER_W-1:0]          escape_count,
    output logic                       in_set
);

    localparam int ZW  = FRAC_BITS + 3;
    localparam int NCH = (ZW + 31) / 32;
    localparam int CHW = (ZW + NCH - 1) / NCH;
    localparam int BW  = NCH * CHW;
    localparam int PPW = ZW + CHW + 1;
    localparam int AW  = ZW + BW + 1;
    localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SW  = INDEX_BITS + STEP_W;
    localparam int CXW = INDEX_BITS + STEP_W + 2;
    localparam int NW  = ((CXW > FRAC_BITS + 5) ? CXW : FRAC_BITS + 5) + 1;
    localparam int QW  = FRAC_BITS + 4;

    localparam logic signed [NW-1:0] TWO_ABS = {{(NW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
    localparam logic [QW:0]          FOUR    = {{QW{1'b0}}, 1'b1} << (FRAC_BITS + 2);

    logic [INDEX_BITS-1:0]  col_reg, row_reg;
    logic [SW-1:0]          prodx_reg, prody_reg;
    logic signed [CXW-1:0]  cx_reg, cy_reg;
    logic signed [ZW-1:0]   zx_reg, zy_reg;
    logic [QW-1:0]          xx_reg, yy_reg;
    logic signed [NW-1:0]   xy2_reg;
    logic signed [AW-1:0]   acc_reg, acc_next;
    logic [KW-1:0]          k_reg;
    logic [ITER_W-1:0]      count_reg;
    logic                   in_set_reg;
    logic [ITER_W-1:0]      rem_reg, rem_next;
    logic [ITER_W-1:0]      dq_reg;
    logic [DIV_STEP_W-1:0]  dk_reg;

    logic signed [ZW-1:0]   a_op, b_op;
    logic signed [BW-1:0]   b_ext;
    logic [KW-1:0]          chunk_idx;
    logic [CHW-1:0]         b_chunk;
    logic                   chunk_ext;
    logic signed [PPW-1:0]  pp;
    logic signed [AW-1:0]   sq_full, xy_full;
    logic signed [NW-1:0]   nx, ny, xx_n, yy_n, cx_n, cy_n;
    logic [QW:0]            sq_sum;
    logic [2*ITER_W-1:0]    numer;
    logic [ITER_W:0]        div_t;
    logic                   div_ge;

    // operand selection for the shared multiplier
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_XX:
            begin
                a_op = zx_reg;
                b_op = zx_reg;
            end
            MUL_YY:
            begin
                a_op = zy_reg;
                b_op = zy_reg;
            end
            default:
            begin
                a_op = zx_reg;
                b_op = zy_reg;
            end
        endcase
    end

    // most significant chunk first, top chunk signed
    assign b_ext     = BW'(b_op);
    assign chunk_idx = KW'(NCH - 1) - k_reg;
    assign b_chunk   = b_ext[chunk_idx*CHW +: CHW];
    assign chunk_ext = (k_reg == '0) ? b_chunk[CHW-1] : 1'b0;
    assign pp        = a_op * $signed({chunk_ext, b_chunk});
    assign acc_next  = ((k_reg == '0) ? '0 : (acc_reg <<< CHW)) + AW'(pp);
    assign sq_full   = acc_next >>> FRAC_BITS;
    assign xy_full   = acc_next >>> (FRAC_BITS - 1);

    // next point and bound test
    assign xx_n = NW'({1'b0, xx_reg});
    assign yy_n = NW'({1'b0, yy_reg});
    assign cx_n = NW'(cx_reg);
    assign cy_n = NW'(cy_reg);
    assign nx   = xx_n - yy_n + cx_n;
    assign ny   = xy2_reg + cy_n;

    assign sq_sum = {1'b0, xx_reg} + {1'b0, yy_reg};

    // shade divider, quotient fits eight bits as count never exceeds the limit
    assign numer    = {{ITER_W{1'b0}}, SHADE_SCALE} * {{ITER_W{1'b0}}, count_reg};
    assign div_t    = {rem_reg, dq_reg[ITER_W-1]};
    assign div_ge   = div_t >= {1'b0, limit};
    assign rem_next = div_ge ? ITER_W'(div_t - {1'b0, limit}) : div_t[ITER_W-1:0];

    assign status.bound_esc = (nx > TWO_ABS) || (nx < -TWO_ABS) ||
                              (ny > TWO_ABS) || (ny < -TWO_ABS);
    assign status.sq_esc    = sq_sum > FOUR;
    assign status.at_limit  = count_reg == limit;
    assign status.mul_last  = k_reg == KW'(NCH - 1);
    assign status.div_last  = dk_reg == DIV_STEP_W'(ITER_W - 1);

    assign shade        = in_set_reg ? '0 : dq_reg;
    assign escape_count = count_reg;
    assign in_set       = in_set_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg      <= '0;
            dk_reg     <= '0;
            in_set_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd.mul_go)
            begin
                k_reg <= status.mul_last ? '0 : k_reg + KW'(1);
            end
            if (cmd.div_load)
            begin
                dk_reg <= '0;
            end
            else if (cmd.div_go)
            begin
                dk_reg <= dk_reg + DIV_STEP_W'(1);
            end
            if (cmd.c_init)
            begin
                in_set_reg <= 1'b0;
                count_reg  <= '0;
            end
            else if (cmd.update)
            begin
                count_reg <= count_reg + ITER_W'(1);
            end
            else if (cmd.test && !status.sq_esc && status.at_limit)
            begin
                in_set_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg <= column;
            row_reg <= row;
        end
        if (cmd.c_mul)
        begin
            prodx_reg <= {{STEP_W{1'b0}}, col_reg} * {{INDEX_BITS{1'b0}}, real_step};
            prody_reg <= {{STEP_W{1'b0}}, row_reg} * {{INDEX_BITS{1'b0}}, imag_step};
        end
        if (cmd.c_init)
        begin
            cx_reg <= CXW'(real_origin) + CXW'(prodx_reg);
            cy_reg <= CXW'(imag_origin) + CXW'(prody_reg);
            zx_reg <= '0;
            zy_reg <= '0;
            xx_reg <= '0;
            yy_reg <= '0;
        end
        if (cmd.mul_go)
        begin
            acc_reg <= acc_next;
            if (status.mul_last)
            begin
                case (cmd.mul_sel)
                    MUL_XX:  xx_reg  <= sq_full[QW-1:0];
                    MUL_YY:  yy_reg  <= sq_full[QW-1:0];
                    default: xy2_reg <= xy_full[NW-1:0];
                endcase
            end
        end
        if (cmd.update)
        begin
            zx_reg <= nx[ZW-1:0];
            zy_reg <= ny[ZW-1:0];
        end
        if (cmd.div_load)
        begin
            rem_reg <= numer[2*ITER_W-1:ITER_W];
            dq_reg  <= numer[ITER_W-1:0];
        end
        else if (cmd.div_go)
        begin
            rem_reg <= rem_next;
            dq_reg  <= {dq_reg[ITER_W-2:0], div_ge};
        end
    end

endmodule

// ----- src/mbet_ctrl.sv -----
// controller: sequences point forming, iterations, escape tests and shading
module mbet_ctrl
    import mbet_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_XY;
        busy        = 1'b1;
        done        = 1'b0;
        case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                busy = 1'b0;
                done = state_reg == ST_DONE;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_C_MUL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_C_MUL:
            begin
                cmd.c_mul  = 1'b1;
                state_next = ST_C_INIT;
            end
            ST_C_INIT:
            begin
                cmd.c_init = 1'b1;
                state_next = ST_M_XY;
            end
            ST_M_XY:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_XY;
                if (status.mul_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = status.bound_esc ? ST_D_LOAD : ST_M_XX;
            end
            ST_M_XX:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_XX;
                if (status.mul_last)
                begin
                    state_next = ST_M_YY;
                end
            end
            ST_M_YY:
            begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_YY;
                if (status.mul_last)
                begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                cmd.test = 1'b1;
                if (status.sq_esc || status.at_limit)
                begin
                    state_next = ST_D_LOAD;
                end
                else
                begin
                    state_next = ST_M_XY;
                end
            end
            ST_D_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_D_RUN;
            end
            ST_D_RUN:
            begin
                cmd.div_go = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/mandelbrot_escape_time_pixel.sv -----
// escape-time pixel top level: configuration registers, controller and datapath
// each iteration runs the x*y multiply and update, then, unless the bound test stops it,
// the x*x and y*y multiplies and the square test; a multiply is one chunk at 28 fraction bits
// one pixel at a time on a single shared multiplier, new start taken when idle or done
// results are strobed on done for one cycle and cannot be stalled
// reset is asynchronous, active low: controller idle, registers at their default view
module mandelbrot_escape_time_pixel
    import mbet_pkg::*;
#(
    parameter int INDEX_BITS = DEF_INDEX_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [INDEX_BITS-1:0]  column,
    input  logic [INDEX_BITS-1:0]  row,
    output logic                   done,
    output logic [ITER_W-1:0]      shade,
    output logic [ITER_W-1:0]      escape_count,
    output logic                   in_set,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic signed [ORIGIN_W-1:0] real_origin_reg, imag_origin_reg;
    logic [STEP_W-1:0]          real_step_reg, imag_step_reg;
    logic [ITER_W-1:0]          max_iterations_reg;
    logic [ITER_W-1:0]          limit;
    dp_cmd_t                    cmd;
    dp_status_t                 status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_origin_reg    <= ORIGIN_RST;
            imag_origin_reg    <= ORIGIN_RST;
            real_step_reg      <= STEP_RST;
            imag_step_reg      <= STEP_RST;
            max_iterations_reg <= ITER_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_REAL_ORIGIN:    real_origin_reg    <= $signed(cfg_data[ORIGIN_W-1:0]);
                CFG_IMAG_ORIGIN:    imag_origin_reg    <= $signed(cfg_data[ORIGIN_W-1:0]);
                CFG_REAL_STEP:      real_step_reg      <= cfg_data[STEP_W-1:0];
                CFG_IMAG_STEP:      imag_step_reg      <= cfg_data[STEP_W-1:0];
                CFG_MAX_ITERATIONS: max_iterations_reg <= cfg_data[ITER_W-1:0];
                default:            ;
            endcase
        end
    end

    // a zero limit behaves as one
    assign limit = (max_iterations_reg == '0) ? ITER_W'(1) : max_iterations_reg;

    mbet_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mbet_dp #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .column       (column),
        .row          (row),
        .real_origin  (real_origin_reg),
        .imag_origin  (imag_origin_reg),
        .real_step    (real_step_reg),
        .imag_step    (imag_step_reg),
        .limit        (limit),
        .status       (status),
        .shade        (shade),
        .escape_count (escape_count),
        .in_set       (in_set)
    );

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted pixel did not start work");

    a_in_set_shade: assert property (@(posedge clk) disable iff (!rst_n)
        done && in_set |-> shade == '0)
        else $error("pixel in the set has non-zero shade");

    a_in_set_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && in_set |-> escape_count == limit)
        else $error("pixel in the set does not report the limit");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> escape_count != '0 && escape_count <= limit)
        else $error("escape count out of range");

endmodule

// ----- verif/tb_mandelbrot_escape_time_pixel.sv -----
// self-checking testbench for the escape-time pixel block: scoreboard class, directed and random pixels
module tb_mandelbrot_escape_time_pixel;
    import mbet_pkg::*;

    localparam int INDEX_BITS   = DEF_INDEX_BITS;
    localparam int FRAC_BITS    = DEF_FRAC_BITS;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 1300;
    localparam int REPORT_LIMIT = 10;
    localparam int RANDOM_VIEWS = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = CFG_MAX_ITERATIONS + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = '1;

    typedef struct packed {
        logic [ITER_W-1:0] shade;
        logic [ITER_W-1:0] escape_count;
        logic              in_set;
    } pixel_result_t;

    class shade_scoreboard;
        logic signed [ORIGIN_W-1:0] real_origin;
        logic signed [ORIGIN_W-1:0] imag_origin;
        logic [STEP_W-1:0]          real_step;
        logic [STEP_W-1:0]          imag_step;
        logic [ITER_W-1:0]          max_iter;
        pixel_result_t              pending_q[$];
        int                         mismatches;
        int                         results;
        int                         set_pixels;
        int                         escaped_pixels;

        function new();
            real_origin    = ORIGIN_RST;
            imag_origin    = ORIGIN_RST;
            real_step      = STEP_RST;
            imag_step      = STEP_RST;
            max_iter       = ITER_RST;
            mismatches     = 0;
            results        = 0;
            set_pixels     = 0;
            escaped_pixels = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_REAL_ORIGIN:    real_origin = data;
                CFG_IMAG_ORIGIN:    imag_origin = data;
                CFG_REAL_STEP:      real_step   = data[STEP_W-1:0];
                CFG_IMAG_STEP:      imag_step   = data[STEP_W-1:0];
                CFG_MAX_ITERATIONS: max_iter    = data[ITER_W-1:0];
                default: ;
            endcase
        endfunction

        // fixed-point product rounded towards minus infinity
        function longint fx_mul(longint a, longint b, int s);
            logic signed [127:0] wa;
            logic signed [127:0] wb;
            logic signed [127:0] p;
            wa = a;
            wb = b;
            p  = wa * wb;
            return longint'(p >>> s);
        endfunction

        function pixel_result_t escape_time(logic [INDEX_BITS-1:0] col,
                                            logic [INDEX_BITS-1:0] rw);
            longint        unit;
            longint        bound;
            longint        four_sq;
            longint        cx;
            longint        cy;
            longint        zx;
            longint        zy;
            longint        xx;
            longint        yy;
            longint        xy2;
            int            limit;
            int            step;
            bit            escaped;
            pixel_result_t r;
            unit    = longint'(1) <<< FRAC_BITS;
            bound   = unit * 2;
            four_sq = unit * 4;
            limit   = (max_iter == 0) ? 1 : int'(max_iter);
            cx      = longint'(real_origin) + longint'(col) * longint'(real_step);
            cy      = longint'(imag_origin) + longint'(rw) * longint'(imag_step);
            zx      = 0;
            zy      = 0;
            step    = 0;
            escaped = 1'b0;
            for (int i = 1; i <= limit && !escaped; i++) begin
                xx   = fx_mul(zx, zx, FRAC_BITS);
                yy   = fx_mul(zy, zy, FRAC_BITS);
                xy2  = fx_mul(zx, zy, FRAC_BITS - 1);
                zx   = xx - yy + cx;
                zy   = xy2 + cy;
                step = i;
                if (zx > bound || zx < -bound || zy > bound || zy < -bound)
                    escaped = 1'b1;
                else if (fx_mul(zx, zx, FRAC_BITS) + fx_mul(zy, zy, FRAC_BITS) > four_sq)
                    escaped = 1'b1;
            end
            if (escaped) begin
                r.shade        = ITER_W'(int'(SHADE_SCALE) * step / limit);
                r.escape_count = ITER_W'(step);
                r.in_set       = 1'b0;
            end
            else begin
                r.shade        = '0;
                r.escape_count = ITER_W'(limit);
                r.in_set       = 1'b1;
            end
            return r;
        endfunction

        function void note_pixel(logic [INDEX_BITS-1:0] col, logic [INDEX_BITS-1:0] rw);
            pending_q.push_back(escape_time(col, rw));
        endfunction

        function void check_pixel(logic [ITER_W-1:0] shade, logic [ITER_W-1:0] count,
                                  logic set);
            pixel_result_t want;
            results++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: shade %0d count %0d in_set %0b",
                             shade, count, set);
                return;
            end
            want = pending_q.pop_front();
            if (want.in_set)
                set_pixels++;
            else
                escaped_pixels++;
            if (shade !== want.shade || count !== want.escape_count || set !== want.in_set)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch at %0t: expected shade %0d count %0d in_set %0b, got shade %0d count %0d in_set %0b",
                             $realtime, want.shade, want.escape_count, want.in_set,
                             shade, count, set);
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   busy;
    logic [INDEX_BITS-1:0]  column    = '0;
    logic [INDEX_BITS-1:0]  row       = '0;
    logic                   done;
    logic [ITER_W-1:0]      shade;
    logic [ITER_W-1:0]      escape_count;
    logic                   in_set;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    shade_scoreboard sb = new();
    int              stall_cycles = 0;
    int              pixels_sent  = 0;
    int              views        = 0;
    int              cfg_writes   = 0;

    mandelbrot_escape_time_pixel #(
        .INDEX_BITS(INDEX_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .column      (column),
        .row         (row),
        .done        (done),
        .shade       (shade),
        .escape_count(escape_count),
        .in_set      (in_set),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // transfer monitor
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_pixel(shade, escape_count, in_set);
            if (start && !busy)
                sb.note_pixel(column, row);
            if (done || (start && !busy))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, sb.pending());
        $display("tb_mandelbrot_escape_time_pixel: FAIL");
        $finish;
    end

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    // registers change only once every pixel in flight has returned
    task automatic program_view(input logic [CFG_DATA_W-1:0] ro, input logic [CFG_DATA_W-1:0] io,
                                input logic [CFG_DATA_W-1:0] rs, input logic [CFG_DATA_W-1:0] is,
                                input logic [CFG_DATA_W-1:0] mi);
        start <= 1'b0;
        while (sb.results < pixels_sent)
            @(posedge clk);
        set_reg(CFG_REAL_ORIGIN, ro);
        set_reg(CFG_IMAG_ORIGIN, io);
        set_reg(CFG_REAL_STEP, rs);
        set_reg(CFG_IMAG_STEP, is);
        set_reg(CFG_MAX_ITERATIONS, mi);
        set_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom);
        cfg_write <= 1'b0;
        views++;
    endtask

    task automatic send_pixel(input logic [INDEX_BITS-1:0] c, input logic [INDEX_BITS-1:0] r);
        int idle_pct;
        int gap;
        idle_pct = (pixels_sent < 633) ? 32 : (pixels_sent < 1266) ? 59 : 0;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        column <= c;
        row    <= r;
        do
            @(posedge clk);
        while (busy);
        pixels_sent++;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] ro;
        logic [CFG_DATA_W-1:0] io;
        logic [CFG_DATA_W-1:0] rs;
        logic [CFG_DATA_W-1:0] is;
        logic [ITER_W-1:0]     mi;
        int                    count;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: corners, centre, inside and a bit pattern
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel('1, '0);
        send_pixel('0, '1);
        send_pixel(12'd500, 12'd500);
        send_pixel(12'd250, 12'd500);
        send_pixel(12'hAAA, 12'h555);

        // c on the real axis at +2: sits on the escape circle, leaves on the next step
        program_view(32'h2000_0000, '0, '0, '0, 32'd40);
        send_pixel('0, '0);
        send_pixel('1, '1);

        // c at -2: stays on the boundary for the whole limit
        program_view(32'hE000_0000, '0, '0, '0, 32'd255);
        send_pixel('0, '0);

        // origin extremes, full steps, zero limit
        program_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF00);
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel(12'd1, 12'd1);

        // opposite extremes, step bit above the register ignored, limit of one
        program_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, 32'd1);
        send_pixel('0, '0);
        send_pixel('1, 12'h5A5);

        // a small limit over the main cardioid, then the reset origins and steps at a limit of 255
        program_view(32'hF400_0000, 32'hFC00_0000, 32'd65536, 32'd65536, 32'd2);
        send_pixel(12'd64, 12'd64);
        send_pixel(12'd900, 12'd10);
        program_view(32'hE000_0000, 32'hE000_0000, 32'd1073742, 32'd1073742, 32'd255);
        send_pixel(12'd375, 12'd500);
        send_pixel(12'd600, 12'd700);
        send_pixel(12'd560, 12'd540);

        for (int v = 0; v < RANDOM_VIEWS; v++) begin
            case (v % 8)
                0:       mi = 8'd255;
                1:       mi = 8'd1;
                2:       mi = 8'd0;
                3:       mi = 8'd2;
                4:       mi = 8'd40;
                default: mi = ITER_W'($urandom_range(3, 120));
            endcase
            if (v % 4 == 3) begin
                ro = $urandom;
                io = $urandom;
                rs = $urandom;
                is = $urandom;
            end
            else begin
                // windows around the set, about 1024 pixels across
                ro = $urandom_range(0, 32'h3000_0000) - 32'h2800_0000;
                io = $urandom_range(0, 32'h2000_0000) - 32'h1800_0000;
                rs = {1'($urandom_range(0, 1)), 31'($urandom_range(256, 786432))};
                is = {1'($urandom_range(0, 1)), 31'($urandom_range(256, 786432))};
            end
            program_view(ro, io, rs, is, {24'($urandom), mi});
            count = (mi == 8'd255) ? 30 : 85;
            repeat (count) begin
                if ($urandom_range(0, 4) != 0)
                    send_pixel(INDEX_BITS'($urandom_range(0, 1023)),
                               INDEX_BITS'($urandom_range(0, 1023)));
                else
                    send_pixel(INDEX_BITS'($urandom), INDEX_BITS'($urandom));
            end
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d pixels over %0d register views with %0d register writes",
                 pixels_sent, views, cfg_writes);
        $display("%0d pixels stayed in the set, %0d escaped, %0d mismatches, %0d outstanding",
                 sb.set_pixels, sb.escaped_pixels, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_mandelbrot_escape_time_pixel: PASS");
        else
            $display("tb_mandelbrot_escape_time_pixel: FAIL");
        $finish;
    end

endmodule
